@@ src/adjclk_pkg.sv @@
package adjclk_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned NOW_W    = 63;
  localparam int unsigned DRIFT_W  = 31;
  localparam int unsigned MAG_W    = 30;
  localparam int unsigned SEC_W    = 35;
  localparam int unsigned PROD_W   = TIME_W + MAG_W;

  localparam int unsigned MUL_STEPS = TIME_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [MAG_W-1:0] NS_PER_SEC    = 30'd1000000000;
  localparam logic [MAG_W-1:0] DRIFT_LIMIT   = 30'd1000000000;
  localparam logic [47:0]      PPM_UNITS_MAX = 48'd1000000;
  localparam logic [MAG_W-1:0] PPB_PER_UNIT  = 30'd1000;
  localparam int unsigned      PPM_SHIFT     = 16;

endpackage

@@ src/adjclk_mul.sv @@
module adjclk_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [adjclk_pkg::TIME_W-1:0]       a_i,
  input  logic [adjclk_pkg::MAG_W-1:0]        b_i,
  output logic                                done_o,
  output logic [adjclk_pkg::PROD_W-1:0]       prod_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [adjclk_pkg::MUL_CNT_W-1:0]   cnt_q;
  logic [adjclk_pkg::MAG_W-1:0]       hi_q;
  logic [adjclk_pkg::TIME_W-1:0]      lo_q;
  logic [adjclk_pkg::MAG_W-1:0]       b_q;
  logic [adjclk_pkg::MAG_W:0]         sum;

  // one multiplier bit per cycle, product shifts out to the right
  always_comb begin
    sum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? b_q : {adjclk_pkg::MAG_W{1'b0}})};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == adjclk_pkg::MUL_CNT_W'(adjclk_pkg::MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= a_i;
      b_q  <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[adjclk_pkg::MAG_W:1];
      lo_q <= {sum[0], lo_q[adjclk_pkg::TIME_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

@@ src/adjclk_div.sv @@
module adjclk_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [adjclk_pkg::PROD_W-1:0]       num_i,
  output logic                                done_o,
  output logic [adjclk_pkg::TIME_W-1:0]       quo_o,
  output logic [adjclk_pkg::MAG_W-1:0]        rem_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [adjclk_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [adjclk_pkg::PROD_W-1:0]      num_q;
  logic [adjclk_pkg::MAG_W-1:0]       rem_q;
  logic [adjclk_pkg::TIME_W-1:0]      quo_q;
  logic [adjclk_pkg::MAG_W:0]         trial;
  logic [adjclk_pkg::MAG_W:0]         diff;
  logic                               ge;
  logic [adjclk_pkg::MAG_W-1:0]       rem_next;

  // restoring division by 1e9, one dividend bit per cycle, MSB first
  always_comb begin
    trial    = {rem_q, num_q[adjclk_pkg::PROD_W-1]};
    diff     = trial - {1'b0, adjclk_pkg::NS_PER_SEC};
    ge       = (trial >= {1'b0, adjclk_pkg::NS_PER_SEC});
    rem_next = ge ? diff[adjclk_pkg::MAG_W-1:0] : trial[adjclk_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == adjclk_pkg::DIV_CNT_W'(adjclk_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[adjclk_pkg::PROD_W-2:0], 1'b0};
      rem_q <= rem_next;
      quo_q <= {quo_q[adjclk_pkg::TIME_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ src/adjustable_ns_clock.sv @@
// channel | signals                                      | direction
// --------+----------------------------------------------+----------
// request | in_valid_i, in_stall_o, command_i, now_ns_i, | in
//         | value_i                                      |
// result  | out_valid_o, out_stall_i, time_ns_o,         | out
//         | time_seconds_o, time_subseconds_o            |
// Adjust time and set time are applied when accepted and leave the block idle; adjust
// frequency and read step through PREP, MUL, DIV1 and ADD, and a read goes on through
// DIV2 and OUT to the output register, using a 64-step bit-serial multiply and one or two
// 94-step bit-serial divisions by 1e9 in a single shared divider.
// Reset clears the time base, offset and drift to zero.
// One request at a time; a finished result waits in the output register while out_stall_i
// is high, and requests are still taken; a read that finishes meanwhile holds the input.
module adjustable_ns_clock (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [adjclk_pkg::NOW_W-1:0]        now_ns_i,
  input  logic signed [adjclk_pkg::TIME_W-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [adjclk_pkg::TIME_W-1:0] time_ns_o,
  output logic signed [adjclk_pkg::SEC_W-1:0]  time_seconds_o,
  output logic [adjclk_pkg::MAG_W-1:0]        time_subseconds_o
);

  typedef enum logic [1:0] {
    CMD_FREQ,
    CMD_ADJ,
    CMD_SET,
    CMD_READ
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV1,
    ST_ADD,
    ST_DIV2,
    ST_OUT
  } state_e;

  state_e                             state_q;
  cmd_e                               cmd_q;
  logic [adjclk_pkg::NOW_W-1:0]       now_q;
  logic [adjclk_pkg::TIME_W-1:0]      val_q;
  logic [adjclk_pkg::TIME_W-1:0]      el_q;
  logic [adjclk_pkg::TIME_W-1:0]      sum_q;
  logic                               neg_q;
  logic [adjclk_pkg::TIME_W-1:0]      dterm_q;
  logic [adjclk_pkg::DRIFT_W-1:0]     drift_new_q;
  logic [adjclk_pkg::TIME_W-1:0]      t_q;
  logic                               tneg_q;
  logic [adjclk_pkg::TIME_W-1:0]      base_q;
  logic [adjclk_pkg::TIME_W-1:0]      offset_q;
  logic [adjclk_pkg::DRIFT_W-1:0]     drift_q;
  logic                               out_valid_q;
  logic [adjclk_pkg::TIME_W-1:0]      time_ns_q;
  logic [adjclk_pkg::SEC_W-1:0]       sec_q;
  logic [adjclk_pkg::MAG_W-1:0]       sub_q;

  logic                               accept;
  logic [adjclk_pkg::TIME_W-1:0]      mag_el;
  logic [adjclk_pkg::DRIFT_W-1:0]     drift_neg;
  logic [adjclk_pkg::MAG_W-1:0]       mag_drift;
  logic [adjclk_pkg::TIME_W-1:0]      mag_val;
  logic [47:0]                        units;
  logic [adjclk_pkg::MAG_W-1:0]       ppb;
  logic [adjclk_pkg::DRIFT_W-1:0]     drift_new;
  logic [adjclk_pkg::TIME_W-1:0]      t_sum;
  logic [adjclk_pkg::TIME_W-1:0]      t_mag;

  logic                               mul_done;
  logic [adjclk_pkg::PROD_W-1:0]      prod;
  logic                               div_start;
  logic [adjclk_pkg::PROD_W-1:0]      div_num;
  logic                               div_done;
  logic [adjclk_pkg::TIME_W-1:0]      quo;
  logic [adjclk_pkg::MAG_W-1:0]       rem;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    mag_el    = el_q[adjclk_pkg::TIME_W-1] ? (~el_q + 1'b1) : el_q;
    drift_neg = ~drift_q + 1'b1;
    mag_drift = drift_q[adjclk_pkg::DRIFT_W-1] ? drift_neg[adjclk_pkg::MAG_W-1:0]
                                               : drift_q[adjclk_pkg::MAG_W-1:0];
    mag_val   = val_q[adjclk_pkg::TIME_W-1] ? (~val_q + 1'b1) : val_q;
    units     = mag_val[adjclk_pkg::TIME_W-1:adjclk_pkg::PPM_SHIFT];
    ppb       = (units >= adjclk_pkg::PPM_UNITS_MAX) ? adjclk_pkg::DRIFT_LIMIT
              : ({10'b0, units[19:0]} * adjclk_pkg::PPB_PER_UNIT);
    drift_new = val_q[adjclk_pkg::TIME_W-1] ? (~{1'b0, ppb} + 1'b1) : {1'b0, ppb};
    t_sum     = sum_q + dterm_q;
    t_mag     = t_sum[adjclk_pkg::TIME_W-1] ? ~t_sum : t_sum;
    div_start = mul_done || ((state_q == ST_ADD) && (cmd_q == CMD_READ));
    div_num   = (state_q == ST_MUL) ? prod
              : {{(adjclk_pkg::PROD_W - adjclk_pkg::TIME_W){1'b0}}, t_mag};
  end

  adjclk_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_PREP),
    .a_i     (mag_el),
    .b_i     (mag_drift),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  adjclk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .done_o  (div_done),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_FREQ;
      now_q       <= '0;
      val_q       <= '0;
      el_q        <= '0;
      sum_q       <= '0;
      neg_q       <= 1'b0;
      dterm_q     <= '0;
      drift_new_q <= '0;
      t_q         <= '0;
      tneg_q      <= 1'b0;
      base_q      <= '0;
      offset_q    <= '0;
      drift_q     <= '0;
      out_valid_q <= 1'b0;
      time_ns_q   <= '0;
      sec_q       <= '0;
      sub_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q <= cmd_e'(command_i);
            now_q <= now_ns_i;
            val_q <= value_i;
            el_q  <= {1'b0, now_ns_i} - base_q;
            case (cmd_e'(command_i))
              CMD_ADJ: begin
                offset_q <= offset_q + value_i;
              end
              CMD_SET: begin
                offset_q <= value_i - {1'b0, now_ns_i};
                base_q   <= {1'b0, now_ns_i};
              end
              CMD_FREQ, CMD_READ: begin
                state_q <= ST_PREP;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_PREP: begin
          neg_q       <= el_q[adjclk_pkg::TIME_W-1] ^ drift_q[adjclk_pkg::DRIFT_W-1];
          sum_q       <= {1'b0, now_q} + offset_q;
          drift_new_q <= drift_new;
          state_q     <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            state_q <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            dterm_q <= neg_q ? (~quo + 1'b1) : quo;
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (cmd_q == CMD_READ) begin
            t_q     <= t_sum;
            tneg_q  <= t_sum[adjclk_pkg::TIME_W-1];
            state_q <= ST_DIV2;
          end else begin
            offset_q <= offset_q + dterm_q;
            base_q   <= {1'b0, now_q};
            drift_q  <= drift_new_q;
            state_q  <= ST_IDLE;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            time_ns_q   <= t_q;
            // floor split: negative times divide the complement, then flip back
            sec_q       <= tneg_q ? ~quo[adjclk_pkg::SEC_W-1:0] : quo[adjclk_pkg::SEC_W-1:0];
            sub_q       <= tneg_q ? (adjclk_pkg::NS_PER_SEC - 1'b1 - rem) : rem;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign time_ns_o         = time_ns_q;
  assign time_seconds_o    = sec_q;
  assign time_subseconds_o = sub_q;

endmodule

@@ verif/testbench.sv @@
module testbench;

  typedef enum logic [1:0] {
    CMD_ADJ_FREQ = 2'd0,
    CMD_ADJ_TIME = 2'd1,
    CMD_SET_TIME = 2'd2,
    CMD_READ     = 2'd3
  } clk_cmd_e;

  typedef struct packed {
    logic [adjclk_pkg::TIME_W-1:0] ns;
    logic [adjclk_pkg::SEC_W-1:0]  sec;
    logic [adjclk_pkg::MAG_W-1:0]  sub;
  } reading_t;

  localparam int IDLE_LIMIT     = 20000;
  localparam int HOLD_OFF       = 2500;
  localparam int DRAIN_CYCLES   = 400;
  localparam int RANDOM_ITEMS   = 450;
  localparam int PRESSURE_AFTER = 60;

  class ns_clock_tracker;
    logic [adjclk_pkg::TIME_W-1:0] base_ns;
    logic [adjclk_pkg::TIME_W-1:0] offset_ns;
    int                            drift_ppb;
    reading_t                      expected_readings[$];
    int                            mismatches;

    function new();
      base_ns = '0;
      offset_ns = '0;
      drift_ppb = 0;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // (now - base) * drift / 1e9, truncated toward zero, modulo 2^64
    function logic [adjclk_pkg::TIME_W-1:0] drift_correction(
        logic [adjclk_pkg::NOW_W-1:0] now);
      logic [adjclk_pkg::TIME_W-1:0] elapsed;
      logic [adjclk_pkg::TIME_W-1:0] mag;
      logic [adjclk_pkg::TIME_W-1:0] quot;
      logic [127:0]                  prod;
      logic [31:0]                   dmag;
      logic                          neg;
      elapsed = {1'b0, now} - base_ns;
      neg = elapsed[adjclk_pkg::TIME_W-1];
      mag = neg ? (64'd0 - elapsed) : elapsed;
      if (drift_ppb < 0) begin
        neg = !neg;
        dmag = unsigned'(-drift_ppb);
      end else begin
        dmag = unsigned'(drift_ppb);
      end
      prod = 128'(mag) * 128'(dmag);
      quot = 64'(prod / 128'd1000000000);
      return neg ? (64'd0 - quot) : quot;
    endfunction

    function void rebase(logic [adjclk_pkg::NOW_W-1:0] now);
      offset_ns = offset_ns + drift_correction(now);
      base_ns = {1'b0, now};
    endfunction

    function void take_command(clk_cmd_e cmd, logic [adjclk_pkg::NOW_W-1:0] now,
                               logic [adjclk_pkg::TIME_W-1:0] val);
      logic [adjclk_pkg::TIME_W-1:0] mag;
      logic [adjclk_pkg::TIME_W-1:0] units;
      logic [adjclk_pkg::TIME_W-1:0] t;
      longint                        ts;
      longint                        secs;
      longint                        rem;
      int                            ppb;
      reading_t                      r;
      case (cmd)
        CMD_ADJ_FREQ: begin
          mag = val[adjclk_pkg::TIME_W-1] ? (64'd0 - val) : val;
          units = mag >> 16;
          if (units >= 64'd1000000) ppb = 1000000000;
          else ppb = int'(units) * 1000;
          rebase(now);
          drift_ppb = val[adjclk_pkg::TIME_W-1] ? -ppb : ppb;
        end
        CMD_ADJ_TIME: begin
          offset_ns = offset_ns + val;
        end
        CMD_SET_TIME: begin
          rebase(now);
          offset_ns = val - {1'b0, now};
        end
        default: begin
          t = {1'b0, now} + offset_ns + drift_correction(now);
          ts = signed'(t);
          secs = ts / 1000000000;
          rem = ts % 1000000000;
          if (rem < 0) begin
            rem = rem + 1000000000;
            secs = secs - 1;
          end
          r.ns = t;
          r.sec = secs[adjclk_pkg::SEC_W-1:0];
          r.sub = rem[adjclk_pkg::MAG_W-1:0];
          expected_readings.push_back(r);
        end
      endcase
    endfunction

    task check_reading(logic [adjclk_pkg::TIME_W-1:0] t, logic [adjclk_pkg::SEC_W-1:0] s,
                       logic [adjclk_pkg::MAG_W-1:0] sub);
      reading_t want;
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("result with no read pending, time_ns %h", t));
      end else begin
        want = expected_readings.pop_front();
        if (t !== want.ns)
          report_mismatch($sformatf("time_ns got %h expected %h", t, want.ns));
        if (s !== want.sec)
          report_mismatch($sformatf("time_seconds got %h expected %h", s, want.sec));
        if (sub !== want.sub)
          report_mismatch($sformatf("time_subseconds got %h expected %h", sub, want.sub));
      end
    endtask
  endclass

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_stall_o;
  logic [1:0]                           command_i = CMD_READ;
  logic [adjclk_pkg::NOW_W-1:0]         now_ns_i = '0;
  logic signed [adjclk_pkg::TIME_W-1:0] value_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic signed [adjclk_pkg::TIME_W-1:0] time_ns_o;
  logic signed [adjclk_pkg::SEC_W-1:0]  time_seconds_o;
  logic [adjclk_pkg::MAG_W-1:0]         time_subseconds_o;

  ns_clock_tracker              tracker = new();
  int                           requests_sent = 0;
  int                           readings_seen = 0;
  int                           idle_cycles = 0;
  logic [adjclk_pkg::NOW_W-1:0] now_cursor = '0;

  adjustable_ns_clock dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .now_ns_i          (now_ns_i),
    .value_i           (value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .time_ns_o         (time_ns_o),
    .time_seconds_o    (time_seconds_o),
    .time_subseconds_o (time_subseconds_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [adjclk_pkg::TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(clk_cmd_e cmd, logic [adjclk_pkg::NOW_W-1:0] now,
                              logic [adjclk_pkg::TIME_W-1:0] val);
    int gap;
    gap = (requests_sent % 120 < 25) ? 0 : $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    now_ns_i <= now;
    value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_command(cmd, now, val);
    requests_sent++;
  endtask

  task automatic directed_requests();
    send_request(CMD_READ, 63'd0, 64'd0);
    send_request(CMD_READ, '1, '1);
    send_request(CMD_ADJ_FREQ, 63'd1000, (64'd5 << 16) | 64'hFFFF);
    send_request(CMD_READ, 63'd1000000001000, 64'd0);
    send_request(CMD_ADJ_FREQ, 63'd2000000000000, 64'd999999 << 16);
    send_request(CMD_READ, 63'd3000000000000, 64'd0);
    send_request(CMD_ADJ_FREQ, 63'd3000000000000, 64'd1000000 << 16);
    send_request(CMD_READ, '1, 64'd0);
    send_request(CMD_ADJ_FREQ, 63'd4000000000000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(CMD_ADJ_FREQ, 63'd5000000000000, 64'h8000_0000_0000_0000);
    // time base stepping backward
    send_request(CMD_READ, 63'd1000000000000, 64'd0);
    send_request(CMD_ADJ_FREQ, 63'd6000000000000, 64'd0 - ((64'd250 << 16) + 64'd1));
    send_request(CMD_READ, 63'd5000000000007, 64'd0);
    send_request(CMD_ADJ_TIME, 63'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(CMD_READ, 63'd6000000000000, 64'd0);
    send_request(CMD_ADJ_TIME, 63'd0, 64'h8000_0000_0000_0000);
    send_request(CMD_ADJ_TIME, 63'd0, '1);
    send_request(CMD_READ, 63'd6000000000001, 64'd0);
    send_request(CMD_SET_TIME, 63'd7000000000000, '1);
    send_request(CMD_READ, 63'd7000000000000, 64'd0);
    send_request(CMD_SET_TIME, 63'd7000000000000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(CMD_READ, 63'd7001000000000, 64'd0);
    send_request(CMD_ADJ_FREQ, 63'd8000000000000, 64'd0);
    send_request(CMD_SET_TIME, 63'd8000000000000, 64'd1500000000);
    send_request(CMD_READ, 63'd8000000000000, 64'd0);
  endtask

  task automatic random_requests();
    clk_cmd_e                      cmd;
    logic [adjclk_pkg::TIME_W-1:0] val;
    logic [adjclk_pkg::TIME_W-1:0] mag;
    int                            pick;
    int                            n;
    now_cursor = 63'd9000000000000;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_READ;
      else if (pick < 60) cmd = CMD_ADJ_FREQ;
      else if (pick < 78) cmd = CMD_ADJ_TIME;
      else cmd = CMD_SET_TIME;

      pick = $urandom_range(0, 99);
      if (pick < 75) now_cursor = now_cursor + 63'($urandom);
      else if (pick < 88) now_cursor = now_cursor + (63'($urandom_range(0, 3000)) << 32)
                                                    + 63'($urandom);
      else if (pick < 94) now_cursor = now_cursor - 63'($urandom);
      else now_cursor = 63'(rand64());

      pick = $urandom_range(0, 99);
      case (cmd)
        CMD_ADJ_FREQ: begin
          if (pick < 80) begin
            mag = (64'($urandom_range(0, 1100)) << 16) | 64'($urandom_range(0, 65535));
            val = $urandom_range(0, 1) ? (64'd0 - mag) : mag;
          end else begin
            val = rand64();
          end
        end
        CMD_ADJ_TIME: begin
          if (pick < 70) begin
            mag = 64'($urandom);
            val = $urandom_range(0, 1) ? (64'd0 - mag) : mag;
          end else begin
            val = rand64();
          end
        end
        CMD_SET_TIME: begin
          if (pick < 60) val = {2'b00, 30'($urandom), $urandom};
          else val = rand64();
        end
        default: val = rand64();
      endcase
      send_request(cmd, now_cursor, val);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    directed_requests();
    random_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.expected_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int stall;
    forever begin
      @(negedge clk_i);
      if (readings_seen == PRESSURE_AFTER) begin
        stall = HOLD_OFF;
      end else if (readings_seen % 50 < 12) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 12);
      end
      if (stall > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_reading(time_ns_o, time_seconds_o, time_subseconds_o);
      readings_seen++;
    end
  end

endmodule

@@ adjustable_ns_clock.f @@
src/adjclk_pkg.sv
src/adjclk_mul.sv
src/adjclk_div.sv
src/adjustable_ns_clock.sv
verif/testbench.sv
